[rtl/core/fca_pkg.sv]
// Shared types and constants for the chunk allocator.
// Used by the controller, the datapath and the top level.
package fca_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_DOUBLE    = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } fca_cmd_t;

endpackage

[rtl/core/free_list_chunk_allocator.sv]
// Top level of the LIFO free-list chunk allocator.
// Instantiates fca_ctrl and fca_datapath; depends on fca_pkg.
//
// A command is accepted at a clock edge where start is high and busy is low.
// action 0 asks for a chunk, action 1 returns chunk_index to the pool.
// Busy is high for the one execute cycle after acceptance. The result item
// appears on granted_index, status, free_count and total_count for exactly
// one cycle with done high, loaded as the execute state ends; the receiver
// cannot stall it and must take it then. A new command can be accepted in
// the same cycle that done is shown. An item runs the registered read of the
// free stack memory, then the update in the execute state, with busy high.
// Writing cfg_data with cfg_we high sets up the pool again: indices 0 to
// count-1 exist and are free, count saturating at 64. The write takes effect
// at once. The user must issue it only while the block is idle; the block
// itself does not enforce this. Reset empties the pool with no clearing
// pass; the first get then creates index 0.
module free_list_chunk_allocator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      action,
  input  logic [fca_pkg::IDX_W-1:0] chunk_index,
  input  logic                      cfg_we,
  input  logic [fca_pkg::CNT_W-1:0] cfg_data,
  output logic                      done,
  output logic [fca_pkg::IDX_W-1:0] granted_index,
  output logic [1:0]                status,
  output logic [fca_pkg::CNT_W-1:0] free_count,
  output logic [fca_pkg::CNT_W-1:0] total_count
);
  import fca_pkg::*;

  fca_cmd_t cmd;

  fca_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  fca_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .action        (action),
    .chunk_index   (chunk_index),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .done          (done),
    .granted_index (granted_index),
    .status        (status),
    .free_count    (free_count),
    .total_count   (total_count)
  );

  a_free_le_total: assert property (@(posedge clk) disable iff (rst)
    done |-> free_count <= total_count)
    else $error("free count exceeds created count");

  a_exhausted_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EXHAUSTED) |->
      (total_count == CNT_W'(CAPACITY) && free_count == '0))
    else $error("exhausted reported with chunks available");

  a_error_no_grant: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> granted_index == '0)
    else $error("index granted on a failed item");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy ##1 done))
    else $error("accepted item did not complete on schedule");

endmodule

[rtl/core/fca_ctrl.sv]
// Controller of the chunk allocator: accepts a command and sequences one
// execute cycle. Depends on fca_pkg.
module fca_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output fca_pkg::fca_cmd_t cmd
);
  import fca_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state == S_EXEC);
  assign cmd.capture = (state == S_IDLE) && start;
  assign cmd.execute = (state == S_EXEC);

endmodule

[rtl/core/fca_datapath.sv]
// Datapath of the chunk allocator: free stack memory, used flags, counters
// and the result register. Depends on fca_pkg.
module fca_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  fca_pkg::fca_cmd_t          cmd,
  input  logic                       action,
  input  logic [fca_pkg::IDX_W-1:0]  chunk_index,
  input  logic                       cfg_we,
  input  logic [fca_pkg::CNT_W-1:0]  cfg_data,
  output logic                       done,
  output logic [fca_pkg::IDX_W-1:0]  granted_index,
  output logic [1:0]                 status,
  output logic [fca_pkg::CNT_W-1:0]  free_count,
  output logic [fca_pkg::CNT_W-1:0]  total_count
);
  import fca_pkg::*;

  logic [IDX_W-1:0] stack_mem [CAPACITY];
  logic [CAPACITY-1:0] stk_valid;
  logic [CAPACITY-1:0] in_use;
  logic [CNT_W-1:0] depth;
  logic [CNT_W-1:0] created;

  logic             act;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rd_data;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_pos;

  logic [CNT_W-1:0] depth_m1;
  logic [CNT_W-1:0] setup_cnt;
  logic [IDX_W-1:0] top_value;

  logic [CNT_W-1:0] depth_next;
  logic [CNT_W-1:0] created_next;
  logic [IDX_W-1:0] grant_next;
  status_t          status_next;
  logic             set_used;
  logic             push;

  assign depth_m1  = depth - CNT_W'(1);
  assign setup_cnt = (cfg_data > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : cfg_data;
  // A stack slot not written since setup still holds its own position.
  assign top_value = rd_valid ? rd_data : rd_pos;

  always_comb begin
    depth_next   = depth;
    created_next = created;
    grant_next   = '0;
    status_next  = ST_OK;
    set_used     = 1'b0;
    push         = 1'b0;
    if (!act) begin
      if (depth != '0) begin
        depth_next = depth_m1;
        grant_next = top_value;
        set_used   = 1'b1;
      end else if (created < CNT_W'(CAPACITY)) begin
        grant_next   = created[IDX_W-1:0];
        created_next = created + CNT_W'(1);
        set_used     = 1'b1;
      end else begin
        status_next = ST_EXHAUSTED;
      end
    end else begin
      if ({1'b0, idx} >= created) begin
        status_next = ST_INVALID;
      end else if (!in_use[idx]) begin
        status_next = ST_DOUBLE;
      end else begin
        depth_next = depth + CNT_W'(1);
        push       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data <= stack_mem[depth_m1[IDX_W-1:0]];
    end
    if (cmd.execute && push) begin
      stack_mem[depth[IDX_W-1:0]] <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act      <= action;
      idx      <= chunk_index;
      rd_pos   <= depth_m1[IDX_W-1:0];
      rd_valid <= stk_valid[depth_m1[IDX_W-1:0]];
    end
    if (cmd.execute) begin
      granted_index <= grant_next;
      status        <= status_next;
      free_count    <= depth_next;
      total_count   <= created_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      created   <= '0;
      in_use    <= '0;
      stk_valid <= '0;
      done      <= 1'b0;
    end else if (cfg_we) begin
      depth     <= setup_cnt;
      created   <= setup_cnt;
      in_use    <= '0;
      stk_valid <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.execute;
      if (cmd.execute) begin
        depth   <= depth_next;
        created <= created_next;
        if (set_used) begin
          in_use[grant_next] <= 1'b1;
        end
        if (push) begin
          in_use[idx]                   <= 1'b0;
          stk_valid[depth[IDX_W-1:0]]   <= 1'b1;
        end
      end
    end
  end

endmodule

[test/free_list_chunk_allocator_test.sv]
// Self-checking testbench for the free-list chunk allocator: directed and random gets and
// releases across several pool setups, checked against a built-in model of the pool.
// Depends on fca_pkg and free_list_chunk_allocator.
module free_list_chunk_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fca_pkg::*;

  localparam logic ACT_GET     = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;
  localparam int   CYCLE_LIMIT = 100000;
  localparam int   GAP_PCT     = 12;

  typedef enum logic [1:0] {
    REQ_GET,
    REQ_RELEASE,
    REQ_RELEASE_USED,
    REQ_SET_COUNT
  } req_kind_t;

  typedef struct {
    req_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
    bit               quiet;
  } pool_req_t;

  typedef struct {
    logic [IDX_W-1:0] granted;
    status_t          status;
    logic [CNT_W-1:0] free_cnt;
    logic [CNT_W-1:0] total_cnt;
  } chunk_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             action = ACT_GET;
  logic [IDX_W-1:0] chunk_index = '0;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             done;
  logic [IDX_W-1:0] granted_index;
  logic [1:0]       status;
  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] total_count;

  pool_req_t     pending_reqs[$];
  chunk_result_t expected_results[$];
  bit            taken = 1'b0;
  int            fail_count = 0;
  int            cycle_count = 0;

  logic [IDX_W-1:0] pool_stack[CAPACITY];
  bit               chunk_used[CAPACITY];
  int               pool_depth;
  int               pool_created;

  free_list_chunk_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .chunk_index  (chunk_index),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .done         (done),
    .granted_index(granted_index),
    .status       (status),
    .free_count   (free_count),
    .total_count  (total_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void reset_pool(int n);
    if (n > CAPACITY) n = CAPACITY;
    for (int i = 0; i < CAPACITY; i++) begin
      pool_stack[i] = IDX_W'(i);
      chunk_used[i] = 1'b0;
    end
    pool_depth = n;
    pool_created = n;
  endfunction

  function automatic chunk_result_t serve_request(logic act, logic [IDX_W-1:0] idx);
    chunk_result_t r;
    r.granted = '0;
    r.status = ST_OK;
    if (act == ACT_GET) begin
      if (pool_depth > 0) begin
        pool_depth--;
        r.granted = pool_stack[pool_depth];
        chunk_used[r.granted] = 1'b1;
      end else if (pool_created < CAPACITY) begin
        r.granted = IDX_W'(pool_created);
        chunk_used[r.granted] = 1'b1;
        pool_created++;
      end else begin
        r.status = ST_EXHAUSTED;
      end
    end else begin
      if (int'(idx) >= pool_created) begin
        r.status = ST_INVALID;
      end else if (!chunk_used[idx]) begin
        r.status = ST_DOUBLE;
      end else begin
        chunk_used[idx] = 1'b0;
        pool_stack[pool_depth] = idx;
        pool_depth++;
      end
    end
    r.free_cnt = CNT_W'(pool_depth);
    r.total_cnt = CNT_W'(pool_created);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_used_chunk();
    int held[$];
    for (int i = 0; i < CAPACITY; i++) begin
      if (chunk_used[i]) held.push_back(i);
    end
    if (held.size() == 0) return IDX_W'($urandom_range(CAPACITY - 1));
    return IDX_W'(held[$urandom_range(held.size() - 1)]);
  endfunction

  task automatic queue_req(req_kind_t kind, int idx, int count, bit quiet);
    pool_req_t r;
    r.kind = kind;
    r.idx = IDX_W'(idx);
    r.count = CNT_W'(count);
    r.quiet = quiet;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_phase(int count, int n, int get_pct, int used_pct, bit quiet);
    int roll;
    queue_req(REQ_SET_COUNT, 0, count, quiet);
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < get_pct) begin
        queue_req(REQ_GET, $urandom_range(CAPACITY - 1), 0, quiet);
      end else if (roll < get_pct + used_pct) begin
        queue_req(REQ_RELEASE_USED, 0, 0, quiet);
      end else begin
        queue_req(REQ_RELEASE, $urandom_range(CAPACITY - 1), 0, quiet);
      end
    end
  endtask

  // Sender: offers one item at a time and holds it until the block takes it.
  always @(negedge clk) begin
    pool_req_t nxt;
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else if (start && !taken) begin
    end else if (pending_reqs.size() == 0) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      nxt = pending_reqs[0];
      if (nxt.kind == REQ_SET_COUNT) begin
        start <= 1'b0;
        if (expected_results.size() == 0 && !cfg_we) begin
          cfg_we <= 1'b1;
          cfg_data <= nxt.count;
          void'(pending_reqs.pop_front());
        end else begin
          cfg_we <= 1'b0;
        end
      end else if (!nxt.quiet && $urandom_range(99) < GAP_PCT) begin
        start <= 1'b0;
        cfg_we <= 1'b0;
      end else begin
        void'(pending_reqs.pop_front());
        start <= 1'b1;
        cfg_we <= 1'b0;
        action <= (nxt.kind == REQ_GET) ? ACT_GET : ACT_RELEASE;
        chunk_index <= (nxt.kind == REQ_RELEASE_USED) ? pick_used_chunk() : nxt.idx;
      end
    end
  end

  // Receiver: predicts at acceptance and checks each result against the oldest prediction.
  always @(posedge clk) begin
    chunk_result_t want;
    if (rst) begin
      reset_pool(0);
      expected_results.delete();
      taken = 1'b0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: granted_index %0d status %0d", granted_index, status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (granted_index !== want.granted) begin
            $error("granted_index: expected %0d, actual %0d", want.granted, granted_index);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_count++;
          end
          if (free_count !== want.free_cnt) begin
            $error("free_count: expected %0d, actual %0d", want.free_cnt, free_count);
            fail_count++;
          end
          if (total_count !== want.total_cnt) begin
            $error("total_count: expected %0d, actual %0d", want.total_cnt, total_count);
            fail_count++;
          end
        end
      end
      if (cfg_we) reset_pool(int'(cfg_data));
      taken = start && !busy;
      if (taken) expected_results.push_back(serve_request(action, chunk_index));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    // Empty pool after reset: creation, double and invalid releases, reuse.
    queue_req(REQ_GET, 63, 0, 1'b0);
    queue_req(REQ_GET, 0, 0, 1'b0);
    queue_req(REQ_RELEASE, 1, 0, 1'b0);
    queue_req(REQ_RELEASE, 1, 0, 1'b0);
    queue_req(REQ_RELEASE, 2, 0, 1'b0);
    queue_req(REQ_RELEASE, 63, 0, 1'b0);
    queue_req(REQ_GET, 0, 0, 1'b0);
    queue_req(REQ_RELEASE, 0, 0, 1'b0);
    queue_req(REQ_GET, 42, 0, 1'b0);
    // An oversized count saturates to a full pool.
    queue_req(REQ_SET_COUNT, 0, 127, 1'b0);
    queue_req(REQ_GET, 0, 0, 1'b0);
    queue_req(REQ_GET, 21, 0, 1'b0);
    queue_req(REQ_RELEASE, 63, 0, 1'b0);
    queue_req(REQ_RELEASE, 63, 0, 1'b0);
    queue_req(REQ_RELEASE, 0, 0, 1'b0);
    queue_req(REQ_GET, 0, 0, 1'b0);
    queue_req(REQ_RELEASE, 62, 0, 1'b0);
    queue_req(REQ_GET, 0, 0, 1'b0);

    queue_phase(64, 110, 55, 35, 1'b0);
    queue_phase(0, 120, 80, 15, 1'b0);
    queue_phase(127, 120, 45, 45, 1'b1);
    queue_phase(1, 100, 50, 30, 1'b0);
    queue_phase(33, 110, 40, 45, 1'b0);
    queue_phase(63, 110, 75, 15, 1'b0);
    queue_phase($urandom_range(127), 110, 50, 30, 1'b0);
    queue_phase(2, 100, 85, 10, 1'b0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_reqs.size() != 0 || expected_results.size() != 0 || start);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
